>>> hw/rtl/fts_pkg.sv
// ----------------------------------------------------------------------------
// fts_pkg: shared types and constants of the frame time smoother
// Field widths, fixed-point constants, register indexes, unit status and the
// signed saturation helper used by the top level.
// ----------------------------------------------------------------------------
package fts_pkg;

  // Field widths
  localparam int TIME_W    = 48;  // Q32.16 times
  localparam int DELTA_W   = 32;  // Q15.16 signed step
  localparam int CFG_W     = 24;  // Q8.16 configuration values
  localparam int FRAC_BITS = 16;

  // Serial multiplier geometry: magnitude operand times 24-bit operand
  localparam int MUL_A_W = TIME_W + 1;
  localparam int MUL_B_W = CFG_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int SAT_W   = MUL_P_W - FRAC_BITS;

  // Fixed-point constants, Q0.16
  localparam logic [MUL_B_W-1:0] FRAC_NEW   = 24'd6554;   // 0.1
  localparam logic [MUL_B_W-1:0] FRAC_OLD   = 24'd58982;  // 0.9
  localparam logic [MUL_B_W-1:0] MAX_SMOOTH = 24'd9830;   // 0.15

  // Configuration port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_FIXED_FRAME_MODE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_AVERAGE_MODE     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_INCREMENT  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TIME_SCALE       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CLAMP_LIMIT      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BLEND_LIMIT      = 3'd5;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  // Apply a sign to a magnitude and saturate to signed 32 bits
  function automatic logic [DELTA_W-1:0] sat_mag(input logic neg,
                                                 input logic [SAT_W-1:0] mag);
    logic [DELTA_W-1:0] res;
    if (!neg) begin
      res = (mag > SAT_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[DELTA_W-1:0];
    end else begin
      res = (mag >= SAT_W'(32'h8000_0000)) ? 32'h8000_0000
                                            : (32'd0 - mag[DELTA_W-1:0]);
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/frame_time_smoother.sv
// Sequence: a resync loads the reference and goes straight to the output; a fixed-frame tick
//   takes a multiplier pass; a clamp tick takes a multiplier pass, plus the old and new share passes when blending.
// Averaging tick: a ring refill when pending, the ring update, a divider pass over the history sum,
//   the averaging and limit multiplier passes, and a retry pass on the raw time when the jump is too large.
// Throughput: one item at a time; the input stalls until the sequencer returns to idle.
// Reset (synchronous): registers to their reset values, system state cleared, ring refill
//   pending, output empty.
// ----------------------------------------------------------------------------
// frame_time_smoother: scaled system time accumulator
// Advances a Q32.16 system time per tick in fixed-frame, clamp-and-blend or
// moving-average mode; a resync transaction loads the real-time reference.
// ----------------------------------------------------------------------------
module frame_time_smoother #(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               mode,
  input  logic [fts_pkg::TIME_W-1:0]         now_time,
  // Output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [fts_pkg::TIME_W-1:0]         sys_time,
  output logic signed [fts_pkg::DELTA_W-1:0] delta,
  output logic                               clamped,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fts_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [fts_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [fts_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int TIME_W  = fts_pkg::TIME_W;
  localparam int DELTA_W = fts_pkg::DELTA_W;
  localparam int CFG_W   = fts_pkg::CFG_W;
  localparam int DIFF_W  = TIME_W + 1;
  localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W   = TIME_W + $clog2(HISTORY_DEPTH);
  localparam int LIM_W   = 22;
  localparam int FB      = fts_pkg::FRAC_BITS;

  // Sequencer states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DIFF      = 4'd1;
  localparam logic [3:0] S_CLAMP     = 4'd2;
  localparam logic [3:0] S_MSTART    = 4'd3;
  localparam logic [3:0] S_MUL_W     = 4'd4;
  localparam logic [3:0] S_BLEND     = 4'd5;
  localparam logic [3:0] S_BLEND_SAT = 4'd6;
  localparam logic [3:0] S_FILL      = 4'd7;
  localparam logic [3:0] S_SLOT      = 4'd8;
  localparam logic [3:0] S_SUB       = 4'd9;
  localparam logic [3:0] S_ADD       = 4'd10;
  localparam logic [3:0] S_DSTART    = 4'd11;
  localparam logic [3:0] S_DIV_W     = 4'd12;
  localparam logic [3:0] S_OUT       = 4'd13;

  // Multiplier pass codes
  localparam logic [2:0] OP_FIXED  = 3'd0;
  localparam logic [2:0] OP_CLAMP  = 3'd1;
  localparam logic [2:0] OP_BL_OLD = 3'd2;
  localparam logic [2:0] OP_BL_NEW = 3'd3;
  localparam logic [2:0] OP_AVG    = 3'd4;
  localparam logic [2:0] OP_LIMIT  = 3'd5;
  localparam logic [2:0] OP_RETRY  = 3'd6;

  // Configuration registers
  logic             fixed_frame_mode;
  logic             average_mode;
  logic [CFG_W-1:0] frame_increment;
  logic [CFG_W-1:0] time_scale;
  logic [CFG_W-1:0] clamp_limit;
  logic [CFG_W-1:0] blend_limit;

  // Architectural state
  logic [TIME_W-1:0]  system_time;
  logic [TIME_W-1:0]  real_reference;
  logic [DELTA_W-1:0] last_delta;
  logic               refill_history;
  logic [SLOT_W-1:0]  ring_slot;
  logic [SUM_W-1:0]   history_sum;
  logic [TIME_W-1:0]  hist_mem [HISTORY_DEPTH];
  logic [TIME_W-1:0]  hist_rd;

  // Sequencer and working registers
  logic [3:0]         state;
  logic [2:0]         mul_op;
  logic [SLOT_W-1:0]  fill_idx;
  logic [TIME_W-1:0]  now_r;
  logic [TIME_W-1:0]  base_r;
  logic [DIFF_W-1:0]  diff;
  logic [TIME_W-1:0]  p_old;
  logic [DELTA_W-1:0] res_delta;
  logic               res_clamped;
  logic               res_tick;

  // Arithmetic units
  logic                            mul_start;
  logic [fts_pkg::MUL_A_W-1:0]     mul_a;
  logic [fts_pkg::MUL_B_W-1:0]     mul_b;
  logic [fts_pkg::MUL_P_W-1:0]     mul_product;
  fts_pkg::unit_status_t           mul_status;
  logic                            div_start;
  logic [SUM_W-1:0]                div_quotient;
  fts_pkg::unit_status_t           div_status;

  // Derived values
  logic                    in_accept;
  logic                    out_free;
  logic                    cfg_write;
  logic [DIFF_W-1:0]       diff_mag;
  logic [DELTA_W-1:0]      delta_mag;
  logic [DELTA_W-1:0]      scaled;
  logic [LIM_W-1:0]        avg_limit;
  logic                    too_large;
  logic                    blend_en;
  logic [SLOT_W-1:0]       slot_inc;
  logic [TIME_W-1:0]       sys_sum;
  logic                    hist_we;
  logic [SLOT_W-1:0]       hist_waddr;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  assign diff_mag  = diff[DIFF_W-1] ? (DIFF_W'(0) - diff) : diff;
  assign delta_mag = res_delta[DELTA_W-1] ? (DELTA_W'(0) - res_delta) : res_delta;
  assign scaled    = fts_pkg::sat_mag(diff[DIFF_W-1] && (mul_op != OP_FIXED),
                                      mul_product[fts_pkg::MUL_P_W-1:FB]);
  assign avg_limit = mul_product[FB +: LIM_W];
  assign too_large = !res_delta[DELTA_W-1] &&
                     (res_delta[DELTA_W-2:0] > (DELTA_W - 1)'(avg_limit));
  assign blend_en  = !last_delta[DELTA_W-1] && (last_delta != '0) &&
                     (last_delta[DELTA_W-2:0] < (DELTA_W - 1)'(blend_limit));
  assign slot_inc  = (ring_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : ring_slot + 1'b1;
  assign sys_sum   = system_time + {{(TIME_W - DELTA_W){res_delta[DELTA_W-1]}}, res_delta};

  // Select multiplier operands for the current pass
  assign mul_start = (state == S_MSTART);
  always_comb begin
    case (mul_op)
      OP_FIXED: begin
        mul_a = fts_pkg::MUL_A_W'(frame_increment);
        mul_b = time_scale;
      end
      OP_BL_OLD: begin
        mul_a = fts_pkg::MUL_A_W'(last_delta[DELTA_W-2:0]);
        mul_b = fts_pkg::FRAC_OLD;
      end
      OP_BL_NEW: begin
        mul_a = fts_pkg::MUL_A_W'(delta_mag);
        mul_b = fts_pkg::FRAC_NEW;
      end
      OP_LIMIT: begin
        mul_a = fts_pkg::MUL_A_W'(time_scale);
        mul_b = fts_pkg::MAX_SMOOTH;
      end
      default: begin
        mul_a = diff_mag;
        mul_b = time_scale;
      end
    endcase
  end

  fts_smul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_product),
    .status  (mul_status)
  );

  assign div_start = (state == S_DSTART);

  fts_sdiv #(
    .N_W     (SUM_W),
    .DIVISOR (HISTORY_DEPTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (history_sum),
    .quotient (div_quotient),
    .status   (div_status)
  );

  // History ring memory: one write port, one registered read port
  assign hist_we    = (state == S_FILL) || (state == S_SUB);
  assign hist_waddr = (state == S_FILL) ? fill_idx : ring_slot;
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= now_r;
    end
    if (state == S_SLOT) begin
      hist_rd <= hist_mem[slot_inc];
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (paddr[fts_pkg::APB_ADDR_W-1:2])
      fts_pkg::REG_FIXED_FRAME_MODE: prdata = 32'(fixed_frame_mode);
      fts_pkg::REG_AVERAGE_MODE:     prdata = 32'(average_mode);
      fts_pkg::REG_FRAME_INCREMENT:  prdata = 32'(frame_increment);
      fts_pkg::REG_TIME_SCALE:       prdata = 32'(time_scale);
      fts_pkg::REG_CLAMP_LIMIT:      prdata = 32'(clamp_limit);
      fts_pkg::REG_BLEND_LIMIT:      prdata = 32'(blend_limit);
      default:                       prdata = '0;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_frame_mode <= 1'b0;
      average_mode     <= 1'b1;
      frame_increment  <= 24'd1966;
      time_scale       <= 24'd65536;
      clamp_limit      <= 24'd6554;
      blend_limit      <= 24'd0;
    end else if (cfg_write) begin
      unique case (paddr[fts_pkg::APB_ADDR_W-1:2])
        fts_pkg::REG_FIXED_FRAME_MODE: fixed_frame_mode <= pwdata[0];
        fts_pkg::REG_AVERAGE_MODE:     average_mode     <= pwdata[0];
        fts_pkg::REG_FRAME_INCREMENT:  frame_increment  <= pwdata[CFG_W-1:0];
        fts_pkg::REG_TIME_SCALE:       time_scale       <= pwdata[CFG_W-1:0];
        fts_pkg::REG_CLAMP_LIMIT:      clamp_limit      <= pwdata[CFG_W-1:0];
        fts_pkg::REG_BLEND_LIMIT:      blend_limit      <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, state update and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      system_time    <= '0;
      real_reference <= '0;
      last_delta     <= '0;
      refill_history <= 1'b1;
      ring_slot      <= '0;
      history_sum    <= '0;
    end else begin
      // Drop the output once the transaction is taken, unless a new one loads
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            now_r       <= now_time;
            base_r      <= now_time;
            res_clamped <= 1'b0;
            res_tick    <= !mode;
            fill_idx    <= '0;
            if (mode) begin
              real_reference <= now_time;
              res_delta      <= '0;
              state          <= S_OUT;
            end else if (fixed_frame_mode) begin
              mul_op <= OP_FIXED;
              state  <= S_MSTART;
            end else if (!average_mode) begin
              mul_op <= OP_CLAMP;
              state  <= S_DIFF;
            end else begin
              state <= refill_history ? S_FILL : S_SLOT;
            end
          end
        end

        S_DIFF: begin
          diff  <= {1'b0, base_r} - {1'b0, real_reference};
          state <= (mul_op == OP_CLAMP) ? S_CLAMP : S_MSTART;
        end

        S_CLAMP: begin
          // Limit positive raw steps only
          if ((clamp_limit != '0) && !diff[DIFF_W-1] &&
              (diff[TIME_W-1:0] > TIME_W'(clamp_limit))) begin
            diff        <= DIFF_W'(clamp_limit);
            res_clamped <= 1'b1;
          end
          state <= S_MSTART;
        end

        S_MSTART: begin
          state <= S_MUL_W;
        end

        S_MUL_W: begin
          if (mul_status.done) begin
            case (mul_op)
              OP_FIXED: begin
                res_delta      <= scaled;
                refill_history <= 1'b1;
                state          <= S_OUT;
              end
              OP_CLAMP: begin
                res_delta      <= scaled;
                real_reference <= now_r;
                refill_history <= 1'b1;
                if (blend_en) begin
                  mul_op <= OP_BL_OLD;
                  state  <= S_MSTART;
                end else begin
                  state <= S_OUT;
                end
              end
              OP_BL_OLD: begin
                p_old  <= mul_product[TIME_W-1:0];
                mul_op <= OP_BL_NEW;
                state  <= S_MSTART;
              end
              OP_BL_NEW: begin
                state <= S_BLEND;
              end
              OP_AVG: begin
                res_delta <= scaled;
                mul_op    <= OP_LIMIT;
                state     <= S_MSTART;
              end
              OP_LIMIT: begin
                if (too_large) begin
                  // Fall back to the raw time and refill the ring next tick
                  base_r         <= now_r;
                  refill_history <= 1'b1;
                  mul_op         <= OP_RETRY;
                  state          <= S_DIFF;
                end else begin
                  real_reference <= base_r;
                  state          <= S_OUT;
                end
              end
              default: begin
                res_delta      <= scaled;
                real_reference <= base_r;
                state          <= S_OUT;
              end
            endcase
          end
        end

        S_BLEND: begin
          diff <= res_delta[DELTA_W-1]
                  ? (DIFF_W'(p_old) - DIFF_W'(mul_product[TIME_W-1:0]))
                  : (DIFF_W'(p_old) + DIFF_W'(mul_product[TIME_W-1:0]));
          state <= S_BLEND_SAT;
        end

        S_BLEND_SAT: begin
          res_delta <= fts_pkg::sat_mag(diff[DIFF_W-1],
                                        fts_pkg::SAT_W'(diff_mag[DIFF_W-1:FB]));
          state     <= S_OUT;
        end

        S_FILL: begin
          // Sweep the ring with the current time, summing as it goes
          history_sum <= ((fill_idx == '0) ? '0 : history_sum) + SUM_W'(now_r);
          if (fill_idx == SLOT_W'(HISTORY_DEPTH - 1)) begin
            refill_history <= 1'b0;
            state          <= S_SLOT;
          end else begin
            fill_idx <= fill_idx + 1'b1;
          end
        end

        S_SLOT: begin
          ring_slot <= slot_inc;
          state     <= S_SUB;
        end

        S_SUB: begin
          history_sum <= history_sum - SUM_W'(hist_rd);
          state       <= S_ADD;
        end

        S_ADD: begin
          history_sum <= history_sum + SUM_W'(now_r);
          state       <= S_DSTART;
        end

        S_DSTART: begin
          state <= S_DIV_W;
        end

        S_DIV_W: begin
          if (div_status.done) begin
            base_r <= div_quotient[TIME_W-1:0];
            mul_op <= OP_AVG;
            state  <= S_DIFF;
          end
        end

        S_OUT: begin
          // Hold until the output register is free
          if (out_free) begin
            system_time <= sys_sum;
            sys_time    <= sys_sum;
            delta       <= $signed(res_delta);
            clamped     <= res_clamped;
            out_valid   <= 1'b1;
            if (res_tick) begin
              last_delta <= res_delta;
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall)
    else $error("input taken while an item is in progress");

  a_mul_start_idle: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_status.busy)
    else $error("multiplier restarted while busy");

  a_mul_done_wait: assert property (@(posedge clk) disable iff (rst)
    mul_status.done |-> (state == S_MUL_W))
    else $error("multiplier result arrived outside its wait state");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_status.done |-> (state == S_DIV_W))
    else $error("divider result arrived outside its wait state");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_OUT))
    else $error("output transaction loaded outside the output state");

endmodule

>>> hw/rtl/fts_smul.sv
// ----------------------------------------------------------------------------
// fts_smul: bit-serial shift-add multiplier
// Scans the 24-bit operand one bit per cycle, least significant first, and
// adds the magnitude operand into a right-shifting accumulator.
// ----------------------------------------------------------------------------
module fts_smul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fts_pkg::MUL_A_W-1:0]   a,
  input  logic [fts_pkg::MUL_B_W-1:0]   b,
  output logic [fts_pkg::MUL_P_W-1:0]   product,
  output fts_pkg::unit_status_t         status
);

  localparam int A_W   = fts_pkg::MUL_A_W;
  localparam int B_W   = fts_pkg::MUL_B_W;
  localparam int CNT_W = $clog2(B_W);

  logic [A_W-1:0]   a_reg;
  logic [B_W-1:0]   b_sr;
  logic [A_W-1:0]   acc;
  logic [B_W-1:0]   lo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [A_W:0]     sum;

  // Add the multiplicand when the current multiplier bit is set
  assign sum = {1'b0, acc} + (b_sr[0] ? {1'b0, a_reg} : '0);

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift the partial product right one bit per iteration
  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      b_sr  <= b;
      acc   <= '0;
      lo    <= '0;
    end else if (busy) begin
      acc  <= sum[A_W:1];
      lo   <= {sum[0], lo[B_W-1:1]};
      b_sr <= {1'b0, b_sr[B_W-1:1]};
    end
  end

  assign product = {acc, lo};
  assign status  = '{busy: busy, done: done};

endmodule

>>> hw/rtl/fts_sdiv.sv
// ----------------------------------------------------------------------------
// fts_sdiv: bit-serial restoring divider by a constant
// Shifts the dividend in one bit per cycle, most significant first, and
// keeps a narrow remainder that is compared against the divisor.
// ----------------------------------------------------------------------------
module fts_sdiv #(
  parameter int N_W     = 51,
  parameter int DIVISOR = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [N_W-1:0]        dividend,
  output logic [N_W-1:0]        quotient,
  output fts_pkg::unit_status_t status
);

  localparam int REM_W = $clog2(DIVISOR) + 1;
  localparam int CNT_W = $clog2(N_W);

  logic [N_W-1:0]   shreg;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   trial_sub;
  logic             fits;

  // Trial subtract of the divisor from the partial remainder
  assign trial     = {rem, shreg[N_W-1]};
  assign fits      = trial >= (REM_W + 1)'(DIVISOR);
  assign trial_sub = trial - (REM_W + 1)'(DIVISOR);

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift quotient bits in as dividend bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[N_W-2:0], fits};
      rem   <= fits ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
    end
  end

  assign quotient = shreg;
  assign status   = '{busy: busy, done: done};

endmodule
